// ===== sv/slwbc_pkg.sv =====
// ----------------------------------------------------------------------------
// slwbc_pkg
// Types and codes shared by the single line write-back block cache.
// ----------------------------------------------------------------------------
package slwbc_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SYNC  = 2'd2,
    OP_FILL  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_WB   = 2'd1,
    KIND_REQ  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SIZE_ONE  = 2'd0,
    SIZE_TWO  = 2'd1,
    SIZE_FOUR = 2'd2
  } size_t_t;

  localparam logic CFG_DEVICE = 1'b0;
  localparam logic CFG_BASE   = 1'b1;

  localparam logic [7:0] BYTE_MASK = 8'hff;

endpackage

// ===== sv/single_line_writeback_block_cache.sv =====
// ----------------------------------------------------------------------------
// single_line_writeback_block_cache
// Holds one line of a storage device and serves byte-wise reads and writes.
// ----------------------------------------------------------------------------
// Input beats carry a read, write, sync or fill beat; each is accepted when
// in_valid is high and in_stall is low. Result beats leave on the out channel
// and the final result of an input has last set. Configuration writes use
// cfg_write, cfg_index and cfg_data; the user issues them only while the
// block is idle, and the block itself does not enforce this. Each byte of
// an access takes a line memory read in S_LOOK and then the byte update in
// S_BYTE. A miss with a dirty line first streams BLOCK_BYTES/8 write-back
// beats, each read from the line memory in S_WBRD and sent from S_WBOUT,
// then issues a fill request; the access then waits for fill beats, each
// written into the line memory as it is accepted. A sync writes back a
// dirty line. The result register holds one beat; while out_stall is high
// the block waits with that beat held. Reset clears line and control state;
// the line memory itself is not cleared and no pass over it is made.
// Reads, writes and syncs while a fill is pending, and stray fill beats,
// are taken and ignored.
// ----------------------------------------------------------------------------
module single_line_writeback_block_cache #(
  parameter int BLOCK_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] offset,
  input  logic [1:0]  access_size,
  input  logic [31:0] write_data,
  input  logic [63:0] fill_data,
  input  logic        fill_failed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] read_data,
  output logic        status,
  output logic [3:0]  device,
  output logic [31:0] block_number,
  output logic [63:0] beat_data,
  output logic [4:0]  beat_number,
  output logic        last
);
  import slwbc_pkg::*;

  localparam int IW = $clog2(BLOCK_BYTES);
  localparam int BEATS = BLOCK_BYTES / 8;
  localparam int BW = (BEATS > 1) ? $clog2(BEATS) : 1;
  localparam int RW = (IW > 3) ? IW - 3 : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_BYTE  = 7'b0000100,
    S_WBRD  = 7'b0001000,
    S_WBOUT = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_SEND  = 7'b1000000
  } state_t;

  state_t state;
  logic [3:0]  device_index;
  logic [31:0] base_block;
  logic        line_valid, line_dirty, fill_stale, pend, error_seen;
  logic [31:0] line_block, fill_block;
  logic        pend_rd;
  logic [15:0] pend_offset;
  logic [2:0]  pend_len;
  logic [31:0] pend_wdata, pend_read;
  logic [2:0]  byte_step;
  logic [BW-1:0] fill_count, wb_beat;
  logic        wb_for_sync;

  // Line memory: BLOCK_BYTES/8 rows of eight bytes each, byte-writable.
  logic [7:0]    mem [BEATS][8];
  logic [RW-1:0] rd_row;
  logic [63:0]   rd_data;
  logic          mem_we_row;
  logic [RW-1:0] wr_row;
  logic [63:0]   wr_data;
  logic [7:0]    wr_be;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 8; j++) begin
      if (mem_we_row && wr_be[j]) begin
        mem[wr_row][j] <= wr_data[8*j +: 8];
      end
    end
    for (int j = 0; j < 8; j++) begin
      rd_data[8*j +: 8] <= mem[rd_row][j];
    end
  end

  // Current byte of the access.
  logic [1:0]  k;
  logic [15:0] cur_off;
  logic [31:0] cur_blk;
  logic        hit;
  logic [2:0]  len_next;
  always_comb begin
    k = pend_rd ? 2'(pend_len - 3'd1 - byte_step) : byte_step[1:0];
    cur_off = pend_offset + 16'(k);
    cur_blk = base_block + 32'(cur_off >> IW);
    hit = line_valid && (line_block == cur_blk);
    rd_row = (state == S_WBRD || state == S_WBOUT) ? RW'(wb_beat) :
             RW'(cur_off[IW-1:0] >> 3);
    unique case (access_size)
      SIZE_ONE: len_next = 3'd1;
      SIZE_TWO: len_next = 3'd2;
      default:  len_next = 3'd4;
    endcase
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) && (state != S_WAIT);

  logic out_load;
  assign out_load = out_free && ((state == S_WBOUT) || (state == S_SEND) ||
                                 (state == S_BYTE && !hit && !line_dirty));

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  task automatic put(input kind_t kd, input logic [31:0] rd, input logic st,
                     input logic [3:0] dv, input logic [31:0] bk,
                     input logic [63:0] bd, input logic [4:0] bn, input logic ls);
    kind <= kd;
    read_data <= rd;
    status <= st;
    device <= dv;
    block_number <= bk;
    beat_data <= bd;
    beat_number <= bn;
    last <= ls;
  endtask

  always_comb begin
    mem_we_row = 1'b0;
    wr_row = RW'(fill_count);
    wr_data = fill_data;
    wr_be = 8'hff;
    if (state == S_WAIT && in_acc && operation == OP_FILL && pend) begin
      mem_we_row = 1'b1;
    end else if (state == S_BYTE && hit && !pend_rd) begin
      mem_we_row = 1'b1;
      wr_row = RW'(cur_off[IW-1:0] >> 3);
      wr_data = {8{BYTE_MASK & pend_wdata[8*k +: 8]}};
      wr_be = 8'(1) << cur_off[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      device_index <= '0;
      base_block <= '0;
      line_valid <= 1'b0;
      line_dirty <= 1'b0;
      line_block <= '0;
      fill_block <= '0;
      fill_stale <= 1'b0;
      pend <= 1'b0;
      error_seen <= 1'b0;
      byte_step <= '0;
      fill_count <= '0;
      wb_beat <= '0;
      out_valid <= 1'b0;
      pend_rd <= 1'b0;
      pend_len <= 3'd1;
      wb_for_sync <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      if (cfg_write) begin
        if (cfg_index == CFG_DEVICE && cfg_data[3:0] != device_index) begin
          device_index <= cfg_data[3:0];
          line_valid <= 1'b0;
          fill_stale <= 1'b1;
        end else if (cfg_index == CFG_BASE && cfg_data != base_block) begin
          base_block <= cfg_data;
          line_valid <= 1'b0;
          fill_stale <= 1'b1;
        end
      end
      unique case (state) inside
        S_IDLE, S_WAIT: begin
          if (in_acc) begin
            if (operation == OP_FILL) begin
              if (pend) begin
                if (int'(fill_count) + 1 < BEATS) begin
                  fill_count <= fill_count + BW'(1);
                end else begin
                  fill_count <= '0;
                  pend <= 1'b0;
                  if (fill_failed) begin
                    line_valid <= 1'b0;
                    error_seen <= 1'b1;
                    if (!pend_rd) begin
                      state <= S_SEND;
                    end else begin
                      byte_step <= byte_step + 3'd1;
                      state <= S_LOOK;
                    end
                  end else begin
                    if (!fill_stale) begin
                      line_valid <= 1'b1;
                      line_block <= fill_block;
                    end
                    state <= S_LOOK;
                  end
                end
              end
            end else if (!pend) begin
              if (operation == OP_SYNC) begin
                wb_for_sync <= 1'b1;
                wb_beat <= '0;
                state <= line_dirty ? S_WBRD : S_SEND;
              end else begin
                wb_for_sync <= 1'b0;
                pend_rd <= (operation == OP_READ);
                pend_offset <= offset;
                pend_len <= len_next;
                pend_wdata <= write_data;
                pend_read <= '0;
                byte_step <= '0;
                error_seen <= 1'b0;
                state <= S_LOOK;
              end
            end
          end
        end
        S_LOOK: begin
          if (byte_step >= pend_len) begin
            state <= S_SEND;
          end else begin
            state <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (hit) begin
            if (pend_rd) pend_read[8*k +: 8] <= rd_data[8*cur_off[2:0] +: 8];
            else line_dirty <= 1'b1;
            byte_step <= byte_step + 3'd1;
            state <= S_LOOK;
          end else if (line_dirty) begin
            wb_beat <= '0;
            state <= S_WBRD;
          end else if (out_free) begin
            line_valid <= 1'b0;
            fill_block <= cur_blk;
            fill_count <= '0;
            fill_stale <= 1'b0;
            pend <= 1'b1;
            put(KIND_REQ, '0, 1'b0, device_index, cur_blk, '0, '0, 1'b1);
            state <= S_WAIT;
          end
        end
        S_WBRD: state <= S_WBOUT;
        S_WBOUT: begin
          if (out_free) begin
            put(KIND_WB, '0, 1'b0, device_index, line_block, rd_data,
                5'(wb_beat), 1'b0);
            if (int'(wb_beat) == BEATS - 1) begin
              line_dirty <= 1'b0;
              state <= wb_for_sync ? S_SEND : S_BYTE;
            end else begin
              wb_beat <= wb_beat + BW'(1);
              state <= S_WBRD;
            end
          end
        end
        S_SEND: begin
          if (out_free) begin
            put(KIND_DONE, pend_rd && !wb_for_sync ? pend_read : '0,
                wb_for_sync ? 1'b0 : error_seen, '0, '0, '0, '0, 1'b1);
            wb_for_sync <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> pend)
    else $error("wait state without pending fill");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(kind))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WBOUT) |-> line_dirty)
    else $error("write-back of a clean line");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_REQ) |-> last)
    else $error("fill request not last");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the single line write-back block cache.
// ----------------------------------------------------------------------------
// A short table of directed accesses is run first. It covers reset state,
// block straddles, the wrap of the offset, a failed fill on a read and on a
// write, busy and stray beats, size three and sync. Random phases follow
// under several register settings, the extremes among them. The bench plays
// the storage side and sends a full fill burst, interleaved in random phases,
// whenever a fill is pending. Every result beat is checked field by field
// against a line predictor kept in step with each accepted input beat.
// ----------------------------------------------------------------------------
module tb_top;
  import slwbc_pkg::*;

  localparam int LINE_BYTES = 256;
  localparam int LINE_BEATS = LINE_BYTES / 8;

  typedef struct {
    kind_t       kind;
    logic [31:0] rdata;
    logic        st;
    logic [3:0]  dev;
    logic [31:0] blk;
    logic [63:0] data;
    logic [4:0]  beat;
    logic        last;
  } result_t;

  typedef struct {
    op_t         op;
    logic [15:0] off;
    logic [1:0]  sz;
    logic [31:0] wd;
    logic [63:0] fd;
    logic        ff;
    bit          burst;
    bit          typed;
    kind_t       tkind;
    logic        tst;
    logic [3:0]  tdev;
    logic [31:0] tblk;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [15:0] offset;
  logic [1:0]  access_size;
  logic [31:0] write_data;
  logic [63:0] fill_data;
  logic        fill_failed;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [31:0] read_data;
  logic        status;
  logic [3:0]  device;
  logic [31:0] block_number;
  logic [63:0] beat_data;
  logic [4:0]  beat_number;
  logic        last;

  single_line_writeback_block_cache i_dut (.*);

  // Predictor state of the cached line.
  logic [3:0]  dev_reg;
  logic [31:0] base_reg;
  logic        line_ok;
  logic        line_dirty;
  logic [31:0] line_blk;
  logic [7:0]  line_mem [LINE_BYTES];
  bit          fill_waiting;
  op_t         acc_op;
  logic [15:0] acc_off;
  int          acc_len;
  logic [31:0] acc_wdata;
  logic [31:0] acc_rdata;
  int          acc_step;
  int          fill_beat;
  logic        acc_error;
  logic [31:0] fill_blk;
  bit          fill_stale;

  result_t     expected_results[$];
  result_t     step_results[$];
  int          errors;
  bit          calm;

  function automatic void emit(kind_t k, logic [31:0] rd, logic st, logic [3:0] dv,
                               logic [31:0] bk, logic [63:0] d, logic [4:0] bt);
    result_t r;
    r.kind = k; r.rdata = rd; r.st = st; r.dev = dv; r.blk = bk;
    r.data = d; r.beat = bt; r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void flush_line();
    logic [63:0] d;
    for (int b = 0; b < LINE_BEATS; b++) begin
      for (int j = 0; j < 8; j++) d[8*j +: 8] = line_mem[b*8 + j];
      emit(KIND_WB, '0, 1'b0, dev_reg, line_blk, d, 5'(b));
    end
    line_dirty = 1'b0;
  endfunction

  function automatic void advance_access();
    bit          rd;
    int          k;
    logic [15:0] o;
    logic [31:0] bk;
    int          idx;
    rd = (acc_op == OP_READ);
    while (acc_step < acc_len) begin
      k = rd ? acc_len - 1 - acc_step : acc_step;
      o = acc_off + 16'(k);
      bk = base_reg + 32'(o / LINE_BYTES);
      idx = o % LINE_BYTES;
      if (!(line_ok && line_blk == bk)) begin
        if (line_dirty) flush_line();
        line_ok = 1'b0;
        fill_blk = bk;
        fill_beat = 0;
        fill_stale = 0;
        fill_waiting = 1;
        emit(KIND_REQ, '0, 1'b0, dev_reg, bk, '0, '0);
        return;
      end
      if (rd) begin
        acc_rdata[8*k +: 8] = line_mem[idx];
      end else begin
        line_mem[idx] = acc_wdata[8*k +: 8];
        line_dirty = 1'b1;
      end
      acc_step++;
    end
    fill_waiting = 0;
    emit(KIND_DONE, rd ? acc_rdata : '0, acc_error, '0, '0, '0, '0);
  endfunction

  // Returns 1 when the beat is not ignored by the block.
  function automatic bit cache_step(op_t op, logic [15:0] off, logic [1:0] sz,
                                    logic [31:0] wd, logic [63:0] fd, logic ff);
    step_results.delete();
    if (op == OP_FILL) begin
      if (!fill_waiting) return 0;
      for (int j = 0; j < 8; j++) line_mem[fill_beat*8 + j] = fd[8*j +: 8];
      if (fill_beat + 1 < LINE_BEATS) begin
        fill_beat++;
        return 1;
      end
      fill_beat = 0;
      fill_waiting = 0;
      if (ff) begin
        line_ok = 1'b0;
        acc_error = 1'b1;
        if (acc_op == OP_WRITE) begin
          emit(KIND_DONE, '0, 1'b1, '0, '0, '0, '0);
        end else begin
          acc_step++;
          advance_access();
        end
      end else begin
        if (!fill_stale) begin
          line_ok = 1'b1;
          line_blk = fill_blk;
        end
        advance_access();
      end
    end else begin
      if (fill_waiting) return 0;
      if (op == OP_SYNC) begin
        if (line_dirty) flush_line();
        emit(KIND_DONE, '0, 1'b0, '0, '0, '0, '0);
      end else begin
        acc_op = op;
        acc_off = off;
        acc_len = (sz == SIZE_ONE) ? 1 : (sz == SIZE_TWO) ? 2 : 4;
        acc_wdata = wd;
        acc_rdata = '0;
        acc_step = 0;
        acc_error = 1'b0;
        advance_access();
      end
    end
    if (step_results.size() > 0) step_results[$].last = 1'b1;
    return 1;
  endfunction

  function automatic bit want_idle();
    return !calm && ($urandom_range(99) < 27);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : want_idle();
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", kind);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (kind != e.kind) begin
          $error("kind: expected %0d, actual %0d", e.kind, kind); errors++;
        end
        if (read_data != e.rdata) begin
          $error("read_data: expected %h, actual %h", e.rdata, read_data); errors++;
        end
        if (status != e.st) begin
          $error("status: expected %0d, actual %0d", e.st, status); errors++;
        end
        if (device != e.dev) begin
          $error("device: expected %0d, actual %0d", e.dev, device); errors++;
        end
        if (block_number != e.blk) begin
          $error("block_number: expected %h, actual %h", e.blk, block_number); errors++;
        end
        if (beat_data != e.data) begin
          $error("beat_data: expected %h, actual %h", e.data, beat_data); errors++;
        end
        if (beat_number != e.beat) begin
          $error("beat_number: expected %0d, actual %0d", e.beat, beat_number); errors++;
        end
        if (last != e.last) begin
          $error("last: expected %0d, actual %0d", e.last, last); errors++;
        end
      end
    end
  end

  task automatic drive_beat(op_t op, logic [15:0] off, logic [1:0] sz, logic [31:0] wd,
                            logic [63:0] fd, logic ff, output bit handled);
    while (want_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    offset <= off;
    access_size <= sz;
    write_data <= wd;
    fill_data <= fd;
    fill_failed <= ff;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    handled = cache_step(op, off, sz, wd, fd, ff);
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_reg(logic [0:0] idx, logic [31:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_DEVICE) begin
      if (val[3:0] != dev_reg) begin
        dev_reg = val[3:0]; line_ok = 1'b0; fill_stale = 1;
      end
    end else if (val != base_reg) begin
      base_reg = val; line_ok = 1'b0; fill_stale = 1;
    end
  endtask

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return {8'($urandom_range(2)), 8'($urandom_range(252, 255))};
      2: return 16'($urandom_range(65533, 65535));
      default: return {8'($urandom_range(2)), 8'($urandom)};
    endcase
  endfunction

  task automatic random_phase(int n);
    int  count;
    bit  h;
    op_t op;
    logic ff;
    count = 0;
    while (count < n || fill_waiting) begin
      if (fill_waiting && $urandom_range(99) < 92) begin
        ff = (fill_beat == LINE_BEATS - 1) ? ($urandom_range(99) < 15) : 1'($urandom);
        drive_beat(OP_FILL, 16'($urandom), 2'($urandom), $urandom,
                   {$urandom, $urandom}, ff, h);
      end else begin
        case ($urandom_range(19)) inside
          0, 1: op = OP_FILL;
          2, 3: op = OP_SYNC;
          [4:11]: op = OP_READ;
          default: op = OP_WRITE;
        endcase
        drive_beat(op, pick_offset(), 2'($urandom), $urandom, {$urandom, $urandom},
                   1'($urandom), h);
      end
      if (h) count++;
    end
  endtask

  row_t table_rows[$];

  function automatic row_t mk(op_t op, logic [15:0] off, logic [1:0] sz, logic [31:0] wd,
                              logic [63:0] fd, logic ff, bit burst);
    row_t r;
    r.op = op; r.off = off; r.sz = sz; r.wd = wd; r.fd = fd; r.ff = ff;
    r.burst = burst; r.typed = 0; r.tkind = KIND_DONE; r.tst = 1'b0;
    r.tdev = '0; r.tblk = '0;
    return r;
  endfunction

  function automatic row_t typed_row(row_t r, kind_t k, logic st, logic [31:0] bk);
    r.typed = 1; r.tkind = k; r.tst = st; r.tblk = bk;
    return r;
  endfunction

  initial begin
    bit      h;
    row_t    r;
    result_t t;
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = CFG_DEVICE; cfg_data = '0;
    in_valid = 1'b0; operation = OP_READ; offset = '0; access_size = SIZE_ONE;
    write_data = '0; fill_data = '0; fill_failed = 1'b0; out_stall = 1'b0;
    errors = 0; calm = 0;
    dev_reg = '0; base_reg = '0; line_ok = 1'b0; line_dirty = 1'b0; line_blk = '0;
    foreach (line_mem[i]) line_mem[i] = '0;
    fill_waiting = 0; acc_op = OP_READ; acc_off = '0; acc_len = 0; acc_wdata = '0;
    acc_rdata = '0; acc_step = 0; fill_beat = 0; acc_error = 1'b0; fill_blk = '0;
    fill_stale = 0;

    table_rows.push_back(typed_row(mk(OP_SYNC, 0, SIZE_ONE, 0, 0, 0, 0), KIND_DONE, 0, 0));
    table_rows.push_back(mk(OP_FILL, 0, SIZE_ONE, 0, '1, 1, 0));
    table_rows.push_back(typed_row(mk(OP_READ, 0, SIZE_ONE, 0, 0, 0, 0), KIND_REQ, 0, 0));
    table_rows.push_back(mk(OP_FILL, 0, SIZE_ONE, 0, 64'h0706050403020100, 0, 1));
    table_rows.push_back(mk(OP_WRITE, 16'd254, SIZE_FOUR, 32'hffffffff, 0, 0, 0));
    table_rows.push_back(mk(OP_READ, 16'd3, SIZE_TWO, 0, 0, 0, 0));
    table_rows.push_back(mk(OP_SYNC, 0, SIZE_ONE, 0, 0, 0, 0));
    table_rows.push_back(mk(OP_FILL, 0, SIZE_ONE, 0, 64'h8899aabbccddeeff, 0, 1));
    table_rows.push_back(mk(OP_READ, 16'hfffe, 2'd3, 0, 0, 0, 0));
    table_rows.push_back(mk(OP_FILL, 0, SIZE_ONE, 0, 64'h1122334455667788, 1, 1));
    table_rows.push_back(mk(OP_FILL, 0, SIZE_ONE, 0, 64'h0, 0, 1));
    table_rows.push_back(mk(OP_FILL, 0, SIZE_ONE, 0, '1, 0, 1));
    table_rows.push_back(typed_row(mk(OP_WRITE, 16'h10, SIZE_TWO, '1, 0, 0, 0),
                                   KIND_REQ, 0, 0));
    table_rows.push_back(typed_row(mk(OP_FILL, 0, SIZE_ONE, 0, '1, 1, 1), KIND_DONE, 1, 0));
    table_rows.push_back(mk(OP_WRITE, 16'hffff, SIZE_TWO, 32'h0, 0, 0, 0));
    table_rows.push_back(mk(OP_FILL, 0, SIZE_ONE, 0, 64'h5a5a5a5a5a5a5a5a, 0, 1));
    table_rows.push_back(mk(OP_FILL, 0, SIZE_ONE, 0, 64'ha5a5a5a5a5a5a5a5, 0, 1));
    table_rows.push_back(mk(OP_SYNC, 0, SIZE_ONE, 0, 0, 0, 0));
    table_rows.push_back(typed_row(mk(OP_SYNC, 0, SIZE_ONE, 0, 0, 0, 0), KIND_DONE, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i]) begin
      r = table_rows[i];
      if (r.burst) begin
        for (int b = 0; b < LINE_BEATS; b++) begin
          drive_beat(OP_FILL, r.off, r.sz, r.wd, r.fd + 64'(b),
                     (b == LINE_BEATS - 1) ? r.ff : 1'b0, h);
        end
      end else begin
        drive_beat(r.op, r.off, r.sz, r.wd, r.fd, r.ff, h);
      end
      if (r.typed) begin
        repeat (step_results.size()) void'(expected_results.pop_back());
        t.kind = r.tkind; t.rdata = '0; t.st = r.tst; t.dev = r.tdev; t.blk = r.tblk;
        t.data = '0; t.beat = '0; t.last = 1'b1;
        expected_results.push_back(t);
      end
    end

    set_reg(CFG_DEVICE, 32'd15);
    set_reg(CFG_BASE, 32'hffffffff);
    random_phase(4);
    calm = 1;
    set_reg(CFG_DEVICE, 32'($urandom_range(15)));
    set_reg(CFG_BASE, $urandom);
    random_phase(4);
    calm = 0;
    set_reg(CFG_DEVICE, 32'd0);
    set_reg(CFG_BASE, 32'd0);
    random_phase(4);
    set_reg(CFG_DEVICE, 32'd5);
    set_reg(CFG_BASE, 32'h7fffff00);
    random_phase(4);

    drain();
    if (expected_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
